/* src/sps_pkg.sv */
// Package for the SPS size parser: syntax step codes, field widths and helpers.
// No dependencies.
package sps_pkg;
	localparam int MAX_GOLOMB_ZEROS_DEF = 32;
	localparam int DIM_BITS_DEF = 16;
	localparam int VAL_W = 33;
	localparam int STEP_W = 5;

	localparam logic [STEP_W-1:0] ST_HDR = 5'd0, ST_PROFILE = 5'd1, ST_CONSTR = 5'd2,
		ST_LEVEL = 5'd3, ST_SPSID = 5'd4, ST_CHROMA = 5'd5, ST_RCT = 5'd6, ST_BDL = 5'd7,
		ST_BDC = 5'd8, ST_BYPASS = 5'd9, ST_MATRIX = 5'd10, ST_LIST_FLAG = 5'd11,
		ST_DELTA = 5'd12, ST_LOG2FN = 5'd13, ST_POCTYPE = 5'd14, ST_POCLSB = 5'd15,
		ST_DPAZ = 5'd16, ST_ONRP = 5'd17, ST_OTTB = 5'd18, ST_NCYCLE = 5'd19,
		ST_REFOFF = 5'd20, ST_MAXREF = 5'd21, ST_GAPS = 5'd22, ST_WIDTH = 5'd23,
		ST_HEIGHT = 5'd24, ST_FMO = 5'd25, ST_MBAFF = 5'd26, ST_D8 = 5'd27,
		ST_CROPF = 5'd28, ST_CROP = 5'd29, ST_VUI = 5'd30, ST_DONE = 5'd31;

	localparam logic [1:0] STATUS_OK = 2'd0, STATUS_TRUNC = 2'd1, STATUS_RANGE = 2'd2;

	// Field handed from the bit reader to the syntax walk
	typedef struct packed {
		logic             done;
		logic [VAL_W-1:0] value;
	} fld_t;

	function automatic logic [5:0] fixed_len(input logic [STEP_W-1:0] s);
		unique case (s)
			ST_HDR, ST_PROFILE, ST_CONSTR, ST_LEVEL: fixed_len = 6'd8;
			ST_RCT, ST_BYPASS, ST_MATRIX, ST_LIST_FLAG, ST_DPAZ, ST_GAPS, ST_FMO,
			ST_MBAFF, ST_D8, ST_CROPF, ST_VUI: fixed_len = 6'd1;
			default: fixed_len = 6'd0;
		endcase
	endfunction

	function automatic logic high_profile(input logic [7:0] p);
		high_profile = (p == 8'd100) || (p == 8'd110) || (p == 8'd122) || (p == 8'd244)
			|| (p == 8'd44) || (p == 8'd83) || (p == 8'd86) || (p == 8'd118);
	endfunction
endpackage

/* src/sps_if.sv */
// Valid/ready channel carrying one payload struct.
// Depends on nothing.
interface sps_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* src/h264_sps_size_parser_unit.sv */
// Top level of the SPS size parser: byte shifter, syntax walk, result register.
// Depends on sps_pkg, sps_if, sps_bitreader and sps_dimcalc.

// Each byte is shifted out of an eight-bit register one bit a cycle into the
// field reader. The next byte is accepted only once the shifter has emptied,
// so a new byte is never taken while the last one is still being shifted. On
// the byte marked last, a bit-serial subtractor forms the width and then the
// height over all 39 operand bits, and the result register is loaded after
// that. A unit cut short skips the subtractor and goes straight to the result
// register. No byte is accepted until the result register is free again.
module h264_sps_size_parser_unit import sps_pkg::*; #(
	parameter int MAX_GOLOMB_ZEROS = MAX_GOLOMB_ZEROS_DEF,
	parameter int DIM_BITS = DIM_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	sps_if.sink   in_ch,
	sps_if.source out_ch
);
	localparam logic [1:0] PH_IN = 2'd0, PH_W = 2'd1, PH_H = 2'd2, PH_OUT = 2'd3;

	logic [7:0]       sh_q;
	logic [3:0]       nbits_q;
	logic             last_q;
	logic [1:0]       ph_q;
	logic [STEP_W-1:0] step_q;
	logic [2:0]       lidx_q;
	logic [6:0]       lcnt_q;
	logic [7:0]       lscale_q;
	logic [VAL_W-1:0] ccount_q;
	logic [7:0]       prof_q, lev_q;
	logic [VAL_W-1:0] wu_q, hu_q;
	logic             fonly_q;
	logic [VAL_W-1:0] crop_q [4];
	logic             done_q;
	logic [15:0]      w_q;
	logic             wbad_q;
	logic [1:0]       stat_q;
	logic             ov_q;
	logic [15:0]      ow_q, oh_q;
	logic [1:0]       ost_q;
	logic [7:0]       op_q, ol_q;

	fld_t             fld;
	logic             bit_valid;
	logic             restart;
	logic [STEP_W-1:0] nstep;
	logic [2:0]       nlidx;
	logic [7:0]       nscale;
	logic [6:0]       lsize;
	logic [VAL_W-1:0] v;
	logic             dc_start, dc_busy, dc_done, dc_bad;
	logic [15:0]      dc_dim;
	logic [VAL_W+5:0] full;
	logic [VAL_W+1:0] sub;
	logic             end_byte;

	assign in_ch.ready = (ph_q == PH_IN) && (nbits_q == 4'd0) && !ov_q;
	assign bit_valid = (nbits_q != 4'd0) && !done_q;
	assign v = fld.value;
	assign end_byte = (nbits_q == 4'd1) && last_q;

	sps_bitreader #(.MAX_GOLOMB_ZEROS(MAX_GOLOMB_ZEROS)) u_rd (
		.clk(clk), .arst_n(arst_n), .bit_valid(bit_valid), .bit_in(sh_q[7]),
		.restart(restart), .flen(fixed_len(step_q)), .fld(fld)
	);

	// Syntax walk: next step after a completed field
	always_comb begin
		nstep = step_q;
		nlidx = lidx_q;
		nscale = 8'(lscale_q + (v[0] ? 8'(v[8:1] + 8'd1) : 8'(8'd0 - v[8:1])));
		lsize = (lidx_q < 3'd6) ? 7'd16 : 7'd64;
		unique case (step_q)
			ST_HDR: nstep = ST_PROFILE;
			ST_PROFILE: nstep = ST_CONSTR;
			ST_CONSTR: nstep = ST_LEVEL;
			ST_LEVEL: nstep = ST_SPSID;
			ST_SPSID: nstep = high_profile(prof_q) ? ST_CHROMA : ST_LOG2FN;
			ST_CHROMA: nstep = (v == VAL_W'(3)) ? ST_RCT : ST_BDL;
			ST_RCT: nstep = ST_BDL;
			ST_BDL: nstep = ST_BDC;
			ST_BDC: nstep = ST_BYPASS;
			ST_BYPASS: nstep = ST_MATRIX;
			ST_MATRIX: begin
				nstep = v[0] ? ST_LIST_FLAG : ST_LOG2FN;
				nlidx = '0;
			end
			ST_LIST_FLAG, ST_DELTA: begin
				if ((step_q == ST_LIST_FLAG && v[0])
					|| (step_q == ST_DELTA && lcnt_q + 7'd1 < lsize && nscale != 8'd0)) begin
					nstep = ST_DELTA;
				end else if (lidx_q == 3'd7) begin
					nstep = ST_LOG2FN;
				end else begin
					nstep = ST_LIST_FLAG;
					nlidx = lidx_q + 3'd1;
				end
			end
			ST_LOG2FN: nstep = ST_POCTYPE;
			ST_POCTYPE: nstep = (v == '0) ? ST_POCLSB : ((v == VAL_W'(1)) ? ST_DPAZ : ST_MAXREF);
			ST_POCLSB: nstep = ST_MAXREF;
			ST_DPAZ: nstep = ST_ONRP;
			ST_ONRP: nstep = ST_OTTB;
			ST_OTTB: nstep = ST_NCYCLE;
			ST_NCYCLE: nstep = (v == '0) ? ST_MAXREF : ST_REFOFF;
			ST_REFOFF: nstep = (ccount_q == VAL_W'(1)) ? ST_MAXREF : ST_REFOFF;
			ST_MAXREF: nstep = ST_GAPS;
			ST_GAPS: nstep = ST_WIDTH;
			ST_WIDTH: nstep = ST_HEIGHT;
			ST_HEIGHT: nstep = ST_FMO;
			ST_FMO: nstep = v[0] ? ST_D8 : ST_MBAFF;
			ST_MBAFF: nstep = ST_D8;
			ST_D8: nstep = ST_CROPF;
			ST_CROPF: begin
				nstep = v[0] ? ST_CROP : ST_VUI;
				nlidx = '0;
			end
			ST_CROP: begin
				nstep = (lidx_q >= 3'd3) ? ST_VUI : ST_CROP;
				nlidx = (lidx_q >= 3'd3) ? lidx_q : lidx_q + 3'd1;
			end
			default: nstep = ST_DONE;
		endcase
	end

	assign restart = (ph_q == PH_OUT) && !ov_q;

	// Dimension operands: width at the first start, height at the second
	always_comb begin
		if (ph_q == PH_IN) begin
			full = {(VAL_W+2)'(wu_q) + (VAL_W+2)'(1), 4'b0000};
			sub = {(VAL_W+1)'(crop_q[0]) + (VAL_W+1)'(crop_q[1]), 1'b0};
		end else begin
			full = fonly_q ? {(VAL_W+2)'(hu_q) + (VAL_W+2)'(1), 4'b0000}
				: {(VAL_W+1)'((VAL_W+2)'(hu_q) + (VAL_W+2)'(1)), 5'b00000};
			sub = {(VAL_W+1)'(crop_q[2]) + (VAL_W+1)'(crop_q[3]), 1'b0};
		end
	end

	function automatic logic done_q_next();
		done_q_next = done_q || (bit_valid && fld.done && step_q == ST_VUI);
	endfunction

	assign dc_start = ((ph_q == PH_IN) && end_byte && done_q_next())
		|| ((ph_q == PH_W) && dc_done);

	sps_dimcalc #(.DIM_BITS(DIM_BITS)) u_dim (
		.clk(clk), .arst_n(arst_n), .start(dc_start), .full(full), .sub(sub),
		.busy(dc_busy), .done(dc_done), .dim(dc_dim), .bad(dc_bad)
	);

	// Byte shifter, syntax state and result sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_q <= '0;
			nbits_q <= '0;
			last_q <= 1'b0;
			ph_q <= PH_IN;
			step_q <= ST_HDR;
			lidx_q <= '0;
			lcnt_q <= '0;
			lscale_q <= 8'd8;
			ccount_q <= '0;
			prof_q <= '0;
			lev_q <= '0;
			wu_q <= '0;
			hu_q <= '0;
			fonly_q <= 1'b0;
			for (int i = 0; i < 4; i++) crop_q[i] <= '0;
			done_q <= 1'b0;
			w_q <= '0;
			wbad_q <= 1'b0;
			stat_q <= STATUS_OK;
			ov_q <= 1'b0;
			ow_q <= '0;
			oh_q <= '0;
			ost_q <= STATUS_OK;
			op_q <= '0;
			ol_q <= '0;
		end else begin
			if (out_ch.valid && out_ch.ready) ov_q <= 1'b0;
			if (in_ch.valid && in_ch.ready) begin
				sh_q <= in_ch.data.data_byte;
				nbits_q <= 4'd8;
				last_q <= in_ch.data.last_byte;
			end else if (nbits_q != 4'd0) begin
				sh_q <= {sh_q[6:0], 1'b0};
				nbits_q <= nbits_q - 4'd1;
			end
			if (bit_valid && fld.done) begin
				step_q <= nstep;
				lidx_q <= nlidx;
				unique case (step_q)
					ST_PROFILE: prof_q <= v[7:0];
					ST_LEVEL: lev_q <= v[7:0];
					ST_LIST_FLAG: begin
						lscale_q <= 8'd8;
						lcnt_q <= '0;
					end
					ST_DELTA: begin
						if (nscale != 8'd0) lscale_q <= nscale;
						lcnt_q <= lcnt_q + 7'd1;
					end
					ST_NCYCLE: ccount_q <= v;
					ST_REFOFF: ccount_q <= ccount_q - VAL_W'(1);
					ST_WIDTH: wu_q <= v;
					ST_HEIGHT: hu_q <= v;
					ST_FMO: fonly_q <= v[0];
					ST_CROP: crop_q[lidx_q[1:0]] <= v;
					ST_VUI: done_q <= 1'b1;
					default: ;
				endcase
			end
			unique case (ph_q)
				PH_IN: begin
					if (end_byte) begin
						if (done_q_next()) begin
							ph_q <= PH_W;
							stat_q <= STATUS_OK;
						end else begin
							ph_q <= PH_OUT;
							stat_q <= STATUS_TRUNC;
							w_q <= '0;
							oh_q <= '0;
						end
					end
				end
				PH_W: if (dc_done) begin
					w_q <= dc_dim;
					wbad_q <= dc_bad;
					ph_q <= PH_H;
				end
				PH_H: if (dc_done) begin
					oh_q <= dc_dim;
					if (dc_bad || wbad_q) stat_q <= STATUS_RANGE;
					ph_q <= PH_OUT;
				end
				PH_OUT: if (!ov_q) begin
					// Present result and start the next unit from reset state
					ov_q <= 1'b1;
					ow_q <= w_q;
					ost_q <= stat_q;
					op_q <= prof_q;
					ol_q <= lev_q;
					ph_q <= PH_IN;
					step_q <= ST_HDR;
					lidx_q <= '0;
					lcnt_q <= '0;
					lscale_q <= 8'd8;
					ccount_q <= '0;
					prof_q <= '0;
					lev_q <= '0;
					wu_q <= '0;
					hu_q <= '0;
					fonly_q <= 1'b0;
					for (int i = 0; i < 4; i++) crop_q[i] <= '0;
					done_q <= 1'b0;
				end
				default: ph_q <= PH_IN;
			endcase
		end
	end

	assign out_ch.valid = ov_q;
	assign out_ch.data.width = ow_q;
	assign out_ch.data.height = oh_q;
	assign out_ch.data.profile = op_q;
	assign out_ch.data.level = ol_q;
	assign out_ch.data.status = ost_q;

	// No byte taken while a unit is being closed
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q != PH_IN) |-> !in_ch.ready) else $error("byte accepted while closing unit");
	// The subtractor runs only during the dimension phases
	a_dc_phase: assert property (@(posedge clk) disable iff (!arst_n)
		dc_busy |-> (ph_q == PH_W || ph_q == PH_H)) else $error("subtractor out of phase");
	// A truncation status never carries a nonzero size
	a_trunc: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && ost_q == STATUS_TRUNC) |-> (ow_q == '0 && oh_q == '0))
		else $error("truncated unit with size");
endmodule

/* src/sps_bitreader.sv */
// Serial field reader: fixed-width and Exp-Golomb fields, one valid bit a cycle.
// Depends on sps_pkg.
module sps_bitreader import sps_pkg::*; #(
	parameter int MAX_GOLOMB_ZEROS = MAX_GOLOMB_ZEROS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              bit_valid,
	input  logic              bit_in,
	input  logic              restart,
	input  logic [5:0]        flen,
	output fld_t              fld
);
	logic [5:0]       zeros_q;
	logic [5:0]       left_q;
	logic             suffix_q;
	logic             started_q;
	logic [VAL_W-1:0] val_q;
	logic [VAL_W-1:0] shifted;
	logic [VAL_W-1:0] bias;
	logic [5:0]       cnt_left;

	assign shifted = {val_q[VAL_W-2:0], bit_in};
	assign bias = (VAL_W'(1) << zeros_q) - VAL_W'(1);
	assign cnt_left = started_q ? left_q : flen;

	// Decide completion of the current field
	always_comb begin
		fld.done = 1'b0;
		fld.value = shifted;
		if (bit_valid) begin
			if (flen != 6'd0) begin
				fld.done = (cnt_left == 6'd1);
			end else if (!suffix_q) begin
				if ((bit_in || zeros_q >= 6'(MAX_GOLOMB_ZEROS)) && zeros_q == 6'd0) begin
					fld.done = 1'b1;
					fld.value = '0;
				end
			end else begin
				fld.done = (left_q == 6'd1);
				fld.value = shifted + bias;
			end
		end
	end

	// Advance reader state; restart on each new field
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zeros_q <= '0;
			left_q <= '0;
			suffix_q <= 1'b0;
			started_q <= 1'b0;
			val_q <= '0;
		end else if (restart || (bit_valid && fld.done)) begin
			zeros_q <= '0;
			suffix_q <= 1'b0;
			started_q <= 1'b0;
			val_q <= '0;
		end else if (bit_valid) begin
			if (flen != 6'd0) begin
				val_q <= shifted;
				left_q <= cnt_left - 6'd1;
				started_q <= 1'b1;
			end else if (!suffix_q) begin
				if (bit_in || zeros_q >= 6'(MAX_GOLOMB_ZEROS)) begin
					suffix_q <= 1'b1;
					left_q <= zeros_q;
					val_q <= '0;
				end else begin
					zeros_q <= zeros_q + 6'd1;
				end
			end else begin
				val_q <= shifted;
				left_q <= left_q - 6'd1;
			end
		end
	end
endmodule

/* src/sps_dimcalc.sv */
// Bit-serial dimension calculator: borrow-ripple subtraction and range clamp.
// Depends on sps_pkg.
module sps_dimcalc import sps_pkg::*; #(
	parameter int DIM_BITS = DIM_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [VAL_W+5:0]  full,
	input  logic [VAL_W+1:0]  sub,
	output logic              busy,
	output logic              done,
	output logic [15:0]       dim,
	output logic              bad
);
	localparam int W = VAL_W + 6;
	localparam int LIM = (DIM_BITS >= 16) ? 65535 : ((1 << DIM_BITS) - 1);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;
	logic [W-1:0]  d_q;
	logic          br_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          fin_q;
	logic          d_bit;
	logic          nbr;

	assign d_bit = a_q[0] ^ b_q[0] ^ br_q;
	assign nbr = (~a_q[0] & (b_q[0] | br_q)) | (b_q[0] & br_q);
	assign busy = run_q;

	// Subtract one bit per cycle, least significant first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
			br_q <= 1'b0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W);
				br_q <= 1'b0;
			end else if (run_q) begin
				br_q <= nbr;
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= full;
			b_q <= W'(sub);
		end else if (run_q) begin
			a_q <= a_q >> 1;
			b_q <= b_q >> 1;
			d_q <= {d_bit, d_q[W-1:1]};
		end
	end

	// Clamp: borrow out means negative
	always_comb begin
		done = fin_q;
		bad = 1'b0;
		dim = d_q[15:0];
		if (br_q) begin
			bad = 1'b1;
			dim = '0;
		end else if (d_q > W'(LIM)) begin
			bad = 1'b1;
			dim = 16'(LIM);
		end
	end
endmodule
